// File: src/rsse_pkg.sv
// Shared types, widths and constants for the random step sequencer lane.
// Used by rsse_ctrl, rsse_dp, the top level and the checker.
package rsse_pkg;

    localparam int MAX_STEPS = 16;
    localparam int STEP_W    = (MAX_STEPS > 2) ? $clog2(MAX_STEPS) : 1;
    localparam int LEN_W     = $clog2(MAX_STEPS + 1);
    localparam int DIV_W     = STEP_W + 1;
    localparam int DCNT_W    = $clog2(DIV_W + 1);

    localparam int SC_W    = 5;
    localparam int PER_W   = 22;
    localparam int DYN_W   = 16;
    localparam int RISE_W  = 17;
    localparam int ENV_W   = 24;
    localparam int HOLD_W  = 27;
    localparam int PITCH_W = 16;
    localparam int DRAW_W  = 16;
    localparam int IDX_W   = 4;
    localparam int MAG_W   = 15;

    localparam int JQ_W   = 17;
    localparam int LENP_W = PER_W + LEN_W;
    localparam int MA_W   = LENP_W;
    localparam int MB_W   = JQ_W;
    localparam int MP_W   = MA_W + MB_W;

    localparam int CFG_W     = 24;
    localparam int CFG_IDX_W = 3;

    localparam int IN_W  = 56;
    localparam int OUT_W = 48;

    localparam int OUT_PITCH_LSB = 0;
    localparam int OUT_ENV_LSB   = 16;
    localparam int OUT_RUN_BIT   = 40;

    localparam logic [ENV_W-1:0]  ENV_FULL   = 24'hFFFFFF;
    localparam logic [HOLD_W-1:0] HOLD_MAX   = 27'h7FFFFFF;
    localparam logic [JQ_W-1:0]   JIT_BASE   = 17'd58982;
    localparam logic [JQ_W-1:0]   JIT_SPAN   = 17'd13107;
    localparam logic [DYN_W-1:0]  DYN_MOST_NEG = 16'h8000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_STEP_COUNT = 3'd0,
        CFG_PERIOD     = 3'd1,
        CFG_DYNAMICS   = 3'd2,
        CFG_RISE_TICKS = 3'd3,
        CFG_RISE_STEP  = 3'd4,
        CFG_FALL_STEP  = 3'd5
    } cfg_index_t;

    typedef enum logic [3:0] {
        EG_IDLE = 4'b0001,
        EG_RISE = 4'b0010,
        EG_PEAK = 4'b0100,
        EG_FALL = 4'b1000
    } env_phase_t;

    typedef enum logic [2:0] {
        MUL_NONE   = 3'd0,
        MUL_SQUARE = 3'd1,
        MUL_CUBE   = 3'd2,
        MUL_JITTER = 3'd3,
        MUL_LENGTH = 3'd4,
        MUL_HOLD   = 3'd5
    } mul_op_t;

    typedef struct packed {
        logic    load;
        mul_op_t mul_op;
        logic    update;
        logic    out_load;
    } rsse_cmd_t;

    typedef struct packed {
        logic is_write;
        logic div_done;
    } rsse_status_t;

endpackage

// File: src/rsse_ctrl.sv
// Sequencing state machine for the sequencer lane: handshakes and datapath commands.
// Depends on rsse_pkg.
module rsse_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output rsse_pkg::rsse_cmd_t    cmd,
    input  rsse_pkg::rsse_status_t status
);

    typedef enum logic [7:0] {
        ST_IDLE   = 8'b00000001,
        ST_SQUARE = 8'b00000010,
        ST_JITTER = 8'b00000100,
        ST_LENGTH = 8'b00001000,
        ST_CUBE   = 8'b00010000,
        ST_HOLD   = 8'b00100000,
        ST_UPDATE = 8'b01000000,
        ST_DONE   = 8'b10000000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next   = state_reg;
        cmd.load     = 1'b0;
        cmd.mul_op   = rsse_pkg::MUL_NONE;
        cmd.update   = 1'b0;
        cmd.out_load = 1'b0;
        s_tready     = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_SQUARE;
                end
            end
            ST_SQUARE:
            begin
                cmd.mul_op = rsse_pkg::MUL_SQUARE;
                state_next = status.is_write ? ST_UPDATE : ST_JITTER;
            end
            ST_JITTER:
            begin
                cmd.mul_op = rsse_pkg::MUL_JITTER;
                state_next = ST_LENGTH;
            end
            ST_LENGTH:
            begin
                cmd.mul_op = rsse_pkg::MUL_LENGTH;
                state_next = ST_CUBE;
            end
            ST_CUBE:
            begin
                cmd.mul_op = rsse_pkg::MUL_CUBE;
                state_next = ST_HOLD;
            end
            ST_HOLD:
            begin
                cmd.mul_op = rsse_pkg::MUL_HOLD;
                if (status.div_done)
                    state_next = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                cmd.update = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_tvalid = out_valid_reg;

endmodule

// File: src/rsse_dp.sv
// Datapath of the sequencer lane: config registers, lane state, pitch memory,
// shared multiplier, step remainder unit and output register. Depends on rsse_pkg.
module rsse_dp (
    input  logic                              clk,
    input  logic                              rst_n,
    input  rsse_pkg::rsse_cmd_t                cmd,
    output rsse_pkg::rsse_status_t             status,
    input  logic [rsse_pkg::IN_W-1:0]          s_tdata,
    input  logic                              s_tuser,
    input  logic                              wr_en,
    input  logic [rsse_pkg::CFG_IDX_W-1:0]     wr_index,
    input  logic [rsse_pkg::CFG_W-1:0]         wr_data,
    output logic [rsse_pkg::OUT_W-1:0]         m_tdata
);

    // configuration
    logic [rsse_pkg::SC_W-1:0]   step_count_reg;
    logic [rsse_pkg::PER_W-1:0]  period_reg;
    logic [rsse_pkg::DYN_W-1:0]  dynamics_reg;
    logic [rsse_pkg::RISE_W-1:0] rise_ticks_reg;
    logic [rsse_pkg::ENV_W-1:0]  rise_step_reg;
    logic [rsse_pkg::ENV_W-1:0]  fall_step_reg;

    // captured request
    logic                          cmd_reg;
    logic                          btn_in_reg;
    logic [rsse_pkg::IDX_W-1:0]    idx_reg;
    logic [rsse_pkg::PITCH_W-1:0]  epitch_reg;
    logic [rsse_pkg::DRAW_W-1:0]   chance_reg;
    logic [rsse_pkg::DRAW_W-1:0]   jit_reg;

    // lane state
    logic                          run_reg, run_next;
    logic                          btn_last_reg, btn_last_next;
    logic [rsse_pkg::STEP_W-1:0]   step_reg, step_next;
    logic [rsse_pkg::PER_W-1:0]    phase_reg, phase_next;
    logic [rsse_pkg::HOLD_W-1:0]   hold_reg, hold_next;
    logic [rsse_pkg::PITCH_W-1:0]  held_reg, held_next;
    logic                          mute_reg, mute_next;
    logic [rsse_pkg::ENV_W-1:0]    level_reg, level_next;
    rsse_pkg::env_phase_t           ph_reg, ph_next;
    logic [rsse_pkg::PITCH_W-1:0]  pitch_mem_reg [rsse_pkg::MAX_STEPS];

    // multiplier results
    logic [rsse_pkg::MAG_W-1:0]    sq_reg;
    logic [rsse_pkg::MAG_W-1:0]    cube_reg;
    logic [rsse_pkg::JQ_W-1:0]     jq_reg;
    logic [rsse_pkg::LENP_W-1:0]   len_reg;
    logic [rsse_pkg::LENP_W:0]     hsc_reg;

    // step remainder unit
    logic [rsse_pkg::DIV_W-1:0]    div_x_reg;
    logic [rsse_pkg::LEN_W-1:0]    div_rem_reg;
    logic [rsse_pkg::DCNT_W-1:0]   div_cnt_reg;
    logic [rsse_pkg::LEN_W:0]      div_t;

    logic [rsse_pkg::OUT_W-1:0]    out_reg;

    logic [rsse_pkg::LEN_W-1:0]    lane_len;
    logic [rsse_pkg::PER_W-1:0]    per;
    logic [rsse_pkg::MAG_W-1:0]    mag;
    logic [rsse_pkg::DYN_W-1:0]    dyn_neg;
    logic [rsse_pkg::MA_W-1:0]     mul_a;
    logic [rsse_pkg::MB_W-1:0]     mul_b;
    logic [rsse_pkg::MP_W-1:0]     prod;
    logic [rsse_pkg::LENP_W+1:0]   hsum;
    logic [rsse_pkg::HOLD_W-1:0]   hold_new;
    logic [rsse_pkg::PITCH_W-1:0]  step_pitch;
    logic                          hit;
    logic                          dyn_pos;
    logic                          dyn_neg_sel;
    logic [rsse_pkg::PER_W:0]      phase_inc;
    logic [rsse_pkg::ENV_W-1:0]    env_s;
    logic [rsse_pkg::ENV_W:0]      env_sum;
    logic [rsse_pkg::PITCH_W-1:0]  pitch_out;

    always_comb
    begin
        if (step_count_reg == '0)
            lane_len = rsse_pkg::LEN_W'(1);
        else if (int'(step_count_reg) > rsse_pkg::MAX_STEPS)
            lane_len = rsse_pkg::LEN_W'(rsse_pkg::MAX_STEPS);
        else
            lane_len = rsse_pkg::LEN_W'(step_count_reg);
        per = (period_reg == '0) ? rsse_pkg::PER_W'(1) : period_reg;
        dyn_neg = ~dynamics_reg + rsse_pkg::DYN_W'(1);
        if (dynamics_reg == rsse_pkg::DYN_MOST_NEG)
            mag = '1;
        else if (dynamics_reg[rsse_pkg::DYN_W-1])
            mag = dyn_neg[rsse_pkg::MAG_W-1:0];
        else
            mag = dynamics_reg[rsse_pkg::MAG_W-1:0];
    end

    // shared multiplier
    always_comb
    begin
        case (cmd.mul_op)
            rsse_pkg::MUL_SQUARE:
            begin
                mul_a = rsse_pkg::MA_W'(mag);
                mul_b = rsse_pkg::MB_W'(mag);
            end
            rsse_pkg::MUL_CUBE:
            begin
                mul_a = rsse_pkg::MA_W'(sq_reg);
                mul_b = rsse_pkg::MB_W'(mag);
            end
            rsse_pkg::MUL_JITTER:
            begin
                mul_a = rsse_pkg::MA_W'(jit_reg);
                mul_b = rsse_pkg::JIT_SPAN;
            end
            rsse_pkg::MUL_LENGTH:
            begin
                mul_a = rsse_pkg::MA_W'(per);
                mul_b = rsse_pkg::MB_W'(lane_len);
            end
            rsse_pkg::MUL_HOLD:
            begin
                mul_a = len_reg;
                mul_b = jq_reg;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        prod = rsse_pkg::MP_W'(mul_a) * rsse_pkg::MP_W'(mul_b);
    end

    always_ff @(posedge clk)
    begin
        case (cmd.mul_op)
            rsse_pkg::MUL_SQUARE: sq_reg   <= prod[2*rsse_pkg::MAG_W-1:rsse_pkg::MAG_W];
            rsse_pkg::MUL_CUBE:   cube_reg <= prod[2*rsse_pkg::MAG_W-1:rsse_pkg::MAG_W];
            rsse_pkg::MUL_JITTER: jq_reg   <= rsse_pkg::JIT_BASE
                                              + rsse_pkg::JQ_W'(prod[31:16]);
            rsse_pkg::MUL_LENGTH: len_reg  <= prod[rsse_pkg::LENP_W-1:0];
            rsse_pkg::MUL_HOLD:   hsc_reg  <= prod[16 +: rsse_pkg::LENP_W+1];
            default:
            begin
            end
        endcase
        if (cmd.load)
        begin
            cmd_reg    <= s_tuser;
            btn_in_reg <= s_tdata[0];
            idx_reg    <= s_tdata[4:1];
            epitch_reg <= s_tdata[20:5];
            chance_reg <= s_tdata[36:21];
            jit_reg    <= s_tdata[52:37];
        end
        if (cmd.out_load)
            out_reg <= {7'b0, run_reg, level_reg, pitch_out};
    end

    // (step + 1) mod length, one quotient bit per cycle
    assign div_t = {div_rem_reg, div_x_reg[rsse_pkg::DIV_W-1]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_cnt_reg <= '0;
            div_x_reg   <= '0;
            div_rem_reg <= '0;
        end
        else if (cmd.load)
        begin
            div_cnt_reg <= rsse_pkg::DCNT_W'(rsse_pkg::DIV_W);
            div_x_reg   <= rsse_pkg::DIV_W'(step_reg) + rsse_pkg::DIV_W'(1);
            div_rem_reg <= '0;
        end
        else if (div_cnt_reg != '0)
        begin
            div_cnt_reg <= div_cnt_reg - rsse_pkg::DCNT_W'(1);
            div_x_reg   <= div_x_reg << 1;
            if (div_t >= {1'b0, lane_len})
                div_rem_reg <= rsse_pkg::LEN_W'(div_t - {1'b0, lane_len});
            else
                div_rem_reg <= rsse_pkg::LEN_W'(div_t);
        end
    end

    assign status = '{is_write: cmd_reg, div_done: (div_cnt_reg == '0)};

    // tick update
    always_comb
    begin
        hsum = (rsse_pkg::LENP_W+2)'(hsc_reg) + (rsse_pkg::LENP_W+2)'(rise_ticks_reg);
        hold_new = (hsum > (rsse_pkg::LENP_W+2)'(rsse_pkg::HOLD_MAX))
                   ? rsse_pkg::HOLD_MAX : rsse_pkg::HOLD_W'(hsum);
        step_pitch  = pitch_mem_reg[rsse_pkg::STEP_W'(div_rem_reg)];
        hit         = chance_reg < {cube_reg, 1'b0};
        dyn_pos     = !dynamics_reg[rsse_pkg::DYN_W-1] && (dynamics_reg != '0);
        dyn_neg_sel = dynamics_reg[rsse_pkg::DYN_W-1];

        run_next      = run_reg ^ (btn_in_reg & ~btn_last_reg);
        btn_last_next = btn_in_reg;
        hold_next     = (hold_reg != '0) ? hold_reg - rsse_pkg::HOLD_W'(1) : '0;
        phase_next    = phase_reg;
        step_next     = step_reg;
        mute_next     = mute_reg;
        held_next     = held_reg;
        level_next    = level_reg;
        ph_next       = ph_reg;
        phase_inc     = {1'b0, phase_reg} + (rsse_pkg::PER_W+1)'(1);
        env_s         = '0;
        env_sum       = '0;

        if (run_next)
        begin
            if (phase_inc >= {1'b0, per})
            begin
                phase_next = rsse_pkg::PER_W'(phase_inc - {1'b0, per});
                step_next  = rsse_pkg::STEP_W'(div_rem_reg);
                mute_next  = 1'b0;
                if (hold_next == '0 && ph_reg == rsse_pkg::EG_IDLE)
                begin
                    if (dyn_pos && hit)
                    begin
                        hold_next = hold_new;
                        held_next = step_pitch;
                        ph_next   = rsse_pkg::EG_RISE;
                    end
                    else if (dyn_neg_sel && hit)
                    begin
                        mute_next  = 1'b1;
                        level_next = '0;
                        ph_next    = rsse_pkg::EG_IDLE;
                    end
                    else
                    begin
                        held_next = step_pitch;
                        ph_next   = rsse_pkg::EG_RISE;
                    end
                end
            end
            else
            begin
                phase_next = rsse_pkg::PER_W'(phase_inc);
            end
        end
        else
        begin
            phase_next = '0;
            step_next  = '0;
            hold_next  = '0;
            mute_next  = 1'b0;
            level_next = '0;
            ph_next    = rsse_pkg::EG_IDLE;
        end

        case (ph_next)
            rsse_pkg::EG_RISE:
            begin
                env_s   = (rise_step_reg == '0) ? rsse_pkg::ENV_FULL : rise_step_reg;
                env_sum = {1'b0, level_next} + {1'b0, env_s};
                level_next = (env_sum >= {1'b0, rsse_pkg::ENV_FULL})
                             ? rsse_pkg::ENV_FULL : env_sum[rsse_pkg::ENV_W-1:0];
                if (level_next == rsse_pkg::ENV_FULL)
                    ph_next = (hold_next != '0) ? rsse_pkg::EG_PEAK
                                                : rsse_pkg::EG_FALL;
            end
            rsse_pkg::EG_PEAK:
            begin
                level_next = rsse_pkg::ENV_FULL;
                if (hold_next == '0)
                    ph_next = rsse_pkg::EG_FALL;
            end
            rsse_pkg::EG_FALL:
            begin
                env_s = (fall_step_reg == '0) ? rsse_pkg::ENV_FULL : fall_step_reg;
                if (level_next <= env_s)
                begin
                    level_next = '0;
                    ph_next    = rsse_pkg::EG_IDLE;
                end
                else
                begin
                    level_next = level_next - env_s;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg      <= 1'b0;
            btn_last_reg <= 1'b0;
            step_reg     <= '0;
            phase_reg    <= '0;
            hold_reg     <= '0;
            held_reg     <= '0;
            mute_reg     <= 1'b0;
            level_reg    <= '0;
            ph_reg       <= rsse_pkg::EG_IDLE;
            for (int i = 0; i < rsse_pkg::MAX_STEPS; i++)
                pitch_mem_reg[i] <= '0;
        end
        else if (cmd.update)
        begin
            if (cmd_reg)
            begin
                if (int'(idx_reg) < rsse_pkg::MAX_STEPS)
                    pitch_mem_reg[rsse_pkg::STEP_W'(idx_reg)] <= epitch_reg;
            end
            else
            begin
                run_reg      <= run_next;
                btn_last_reg <= btn_last_next;
                step_reg     <= step_next;
                phase_reg    <= phase_next;
                hold_reg     <= hold_next;
                held_reg     <= held_next;
                mute_reg     <= mute_next;
                level_reg    <= level_next;
                ph_reg       <= ph_next;
            end
        end
    end

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_count_reg <= rsse_pkg::SC_W'(3);
            period_reg     <= rsse_pkg::PER_W'(24000);
            dynamics_reg   <= '0;
            rise_ticks_reg <= '0;
            rise_step_reg  <= rsse_pkg::ENV_FULL;
            fall_step_reg  <= rsse_pkg::ENV_W'(699);
        end
        else if (wr_en)
        begin
            case (rsse_pkg::cfg_index_t'(wr_index))
                rsse_pkg::CFG_STEP_COUNT: step_count_reg <= wr_data[rsse_pkg::SC_W-1:0];
                rsse_pkg::CFG_PERIOD:     period_reg     <= wr_data[rsse_pkg::PER_W-1:0];
                rsse_pkg::CFG_DYNAMICS:   dynamics_reg   <= wr_data[rsse_pkg::DYN_W-1:0];
                rsse_pkg::CFG_RISE_TICKS: rise_ticks_reg <= wr_data[rsse_pkg::RISE_W-1:0];
                rsse_pkg::CFG_RISE_STEP:  rise_step_reg  <= wr_data[rsse_pkg::ENV_W-1:0];
                rsse_pkg::CFG_FALL_STEP:  fall_step_reg  <= wr_data[rsse_pkg::ENV_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    assign pitch_out = (run_reg && !mute_reg) ? held_reg : '0;
    assign m_tdata   = out_reg;

endmodule

// File: src/random_step_sequencer_with_envelope.sv
// Top level of one random step sequencer lane with envelope.
// A sample tick runs the shared multiplier sequence (five products) and waits for
// the one-bit-per-cycle step remainder; a pitch write goes to its update after the first.
// Requests are taken one at a time, the next only after the last result is loaded.
// Reset: rst_n asynchronous, clears all lane state and pitch memory at once,
// configuration returns to its defaults; no clearing pass.
module random_step_sequencer_with_envelope (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // run_button[0], entry_index[4:1], entry_pitch[20:5], chance_draw[36:21],
    // jitter_draw[52:37], zero fill
    input  logic [rsse_pkg::IN_W-1:0]        s_tdata,
    // command[0]
    input  logic                            s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // pitch_out[15:0], envelope_out[39:16], running_out[40], zero fill
    output logic [rsse_pkg::OUT_W-1:0]       m_tdata,
    input  logic                            wr_en,
    input  logic [rsse_pkg::CFG_IDX_W-1:0]   wr_index,
    input  logic [rsse_pkg::CFG_W-1:0]       wr_data
);

    rsse_pkg::rsse_cmd_t    cmd;
    rsse_pkg::rsse_status_t status;

    rsse_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .status   (status)
    );

    rsse_dp u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .status   (status),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data),
        .m_tdata  (m_tdata)
    );

endmodule

// File: src/rsse_chk.sv
// Port-level checker for the sequencer lane, bound to the top level.
// Depends on rsse_pkg.
module rsse_chk (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [rsse_pkg::OUT_W-1:0]       m_tdata
);

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // pitch only while running
    a_pitch_run: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[rsse_pkg::OUT_RUN_BIT]
        |-> m_tdata[rsse_pkg::OUT_PITCH_LSB +: rsse_pkg::PITCH_W] == '0)
        else $error("pitch while stopped");

    // stopped lane has no envelope
    a_env_run: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[rsse_pkg::OUT_RUN_BIT]
        |-> m_tdata[rsse_pkg::OUT_ENV_LSB +: rsse_pkg::ENV_W] == '0)
        else $error("envelope while stopped");

    // one request at a time: no new request in the cycle after one is taken
    a_one_req: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request taken while busy");

endmodule

bind random_step_sequencer_with_envelope rsse_chk u_rsse_chk (.*);

// File: dv/tb_random_step_sequencer_with_envelope.sv
// Testbench for random_step_sequencer_with_envelope. It runs a directed table of ticks and
// pitch writes, then random phases under several register settings, against an in-bench lane model.
// Depends on rsse_pkg and the top-level RTL only.
module tb_random_step_sequencer_with_envelope;
    timeunit 1ns;
    timeprecision 1ps;
    import rsse_pkg::*;

    localparam logic CMD_TICK  = 1'b0;
    localparam logic CMD_WRITE = 1'b1;
    localparam int N_PHASES    = 8;
    localparam int PHASE_ITEMS = 92;
    localparam int DIR_N       = 20;

    typedef struct packed {
        logic               cmd;
        logic               btn;
        logic [IDX_W-1:0]   idx;
        logic [PITCH_W-1:0] pitch;
        logic [DRAW_W-1:0]  chance;
        logic [DRAW_W-1:0]  jitter;
    } lane_req_t;

    typedef struct packed {
        logic [PITCH_W-1:0] pitch;
        logic [ENV_W-1:0]   env;
        logic               run;
    } lane_out_t;

    typedef struct packed {
        lane_req_t req;
        logic      typed;
        lane_out_t want;
    } dir_row_t;

    typedef struct packed {
        logic [SC_W-1:0]   count;
        logic [PER_W-1:0]  period;
        logic [DYN_W-1:0]  dyn;
        logic [RISE_W-1:0] rise_t;
        logic [ENV_W-1:0]  rise_s;
        logic [ENV_W-1:0]  fall_s;
    } lane_cfg_t;

    logic                 clk;
    logic                 rst_n    = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [IN_W-1:0]      s_tdata  = '0;
    logic                 s_tuser  = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [OUT_W-1:0]     m_tdata;
    logic                 wr_en    = 1'b0;
    logic [CFG_IDX_W-1:0] wr_index = '0;
    logic [CFG_W-1:0]     wr_data  = '0;

    random_step_sequencer_with_envelope dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data)
    );

    // lane model state and its copy of the registers
    logic               lane_running;
    logic               btn_was;
    int unsigned        step_pos;
    int unsigned        phase_cnt;
    int unsigned        hold_cnt;
    logic [PITCH_W-1:0] note_pitch;
    logic               muted;
    int unsigned        env_lvl;
    env_phase_t         env_ph;
    logic [PITCH_W-1:0] pitch_mem [MAX_STEPS];
    lane_cfg_t          lane_cfg;

    lane_out_t due_outs [$];
    bit        quiet = 1'b0;
    int        mismatches = 0;
    int        items_sent = 0;
    int        outs_seen = 0;
    int        settings_used = 0;
    int        holds_chosen = 0;
    int        drops_chosen = 0;

    dir_row_t dir_tab [DIR_N] = '{
        '{'{CMD_TICK,  1'b0, 4'd0,  16'h0000, 16'h0000, 16'h0000}, 1'b1, '{16'h0000, 24'h000000, 1'b0}},
        '{'{CMD_WRITE, 1'b0, 4'd0,  16'hFFFF, 16'h0000, 16'h0000}, 1'b1, '{16'h0000, 24'h000000, 1'b0}},
        '{'{CMD_WRITE, 1'b0, 4'd15, 16'h1234, 16'hFFFF, 16'hFFFF}, 1'b1, '{16'h0000, 24'h000000, 1'b0}},
        '{'{CMD_WRITE, 1'b0, 4'd1,  16'hA5A5, 16'h0000, 16'h0000}, 1'b1, '{16'h0000, 24'h000000, 1'b0}},
        '{'{CMD_WRITE, 1'b0, 4'd2,  16'h5A5A, 16'h0000, 16'h0000}, 1'b1, '{16'h0000, 24'h000000, 1'b0}},
        '{'{CMD_TICK,  1'b1, 4'd0,  16'h0000, 16'h8000, 16'h8000}, 1'b1, '{16'hA5A5, 24'hFFFFFF, 1'b1}},
        '{'{CMD_TICK,  1'b1, 4'd0,  16'h0000, 16'hFFFF, 16'hFFFF}, 1'b1, '{16'hA5A5, 24'h000000, 1'b1}},
        '{'{CMD_TICK,  1'b1, 4'd0,  16'h0000, 16'h0000, 16'h0000}, 1'b1, '{16'hFFFF, 24'hFFFFFF, 1'b1}},
        '{'{CMD_WRITE, 1'b0, 4'd3,  16'h0F0F, 16'h0000, 16'h0000}, 1'b1, '{16'hFFFF, 24'hFFFFFF, 1'b1}},
        '{'{CMD_TICK,  1'b0, 4'd0,  16'h0000, 16'h0000, 16'hFFFF}, 1'b0, '0},
        '{'{CMD_WRITE, 1'b1, 4'd4,  16'h0000, 16'h0000, 16'h0000}, 1'b0, '0},
        '{'{CMD_TICK,  1'b0, 4'd0,  16'h0000, 16'h1000, 16'h0000}, 1'b0, '0},
        '{'{CMD_TICK,  1'b1, 4'd0,  16'h0000, 16'h0000, 16'h0000}, 1'b1, '{16'h0000, 24'h000000, 1'b0}},
        '{'{CMD_TICK,  1'b0, 4'd0,  16'h0000, 16'h0000, 16'h0000}, 1'b1, '{16'h0000, 24'h000000, 1'b0}},
        '{'{CMD_TICK,  1'b1, 4'd0,  16'h0000, 16'h0001, 16'h0001}, 1'b0, '0},
        '{'{CMD_TICK,  1'b1, 4'd0,  16'h0000, 16'hFFFF, 16'h0000}, 1'b0, '0},
        '{'{CMD_TICK,  1'b1, 4'd0,  16'h0000, 16'h0000, 16'hFFFF}, 1'b0, '0},
        '{'{CMD_WRITE, 1'b1, 4'd15, 16'hFFFF, 16'hFFFF, 16'hFFFF}, 1'b0, '0},
        '{'{CMD_TICK,  1'b0, 4'd0,  16'h0000, 16'h7FFF, 16'h7FFF}, 1'b0, '0},
        '{'{CMD_TICK,  1'b1, 4'd0,  16'h0000, 16'h0000, 16'h0000}, 1'b1, '{16'h0000, 24'h000000, 1'b0}}
    };

    // count, period, dynamics, rise ticks, rise step, fall step
    lane_cfg_t phase_cfg [N_PHASES] = '{
        '{5'd16, 22'd1,       16'h7FFF, 17'd0,      24'h000000, 24'hFFFFFF},
        '{5'd1,  22'd3,       16'h8000, 17'd5,      24'h400000, 24'h200000},
        '{5'd31, 22'd2,       16'h7FFF, 17'd131071, 24'hFFFFFF, 24'hFFFFFF},
        '{5'd5,  22'd4,       16'hB1E0, 17'd3,      24'h000001, 24'h000001},
        '{5'd17, 22'd7,       16'h61A8, 17'd10,     24'h400000, 24'h300000},
        '{5'd0,  22'd4194303, 16'h0000, 17'd0,      24'hFFFFFF, 24'd699},
        '{5'd16, 22'd2,       16'h8001, 17'd0,      24'hFFFFFF, 24'hFFFFFF},
        '{5'd4,  22'd1,       16'h4E20, 17'd2,      24'h000000, 24'h000000}
    };
    int btn_odds [N_PHASES] = '{12, 12, 16, 12, 12, 60, 12, 12};

    function automatic lane_out_t lane_predict(input lane_req_t r);
        lane_out_t       o;
        int unsigned     len;
        int unsigned     per;
        int unsigned     s;
        int              d;
        longint unsigned m;
        longint unsigned cube;
        longint unsigned jq;
        longint unsigned h;
        if (r.cmd == CMD_WRITE) begin
            pitch_mem[r.idx] = r.pitch;
        end
        else begin
            if (r.btn && !btn_was)
                lane_running = !lane_running;
            btn_was = r.btn;
            if (hold_cnt != 0)
                hold_cnt--;
            if (lane_running) begin
                per = (lane_cfg.period == 0) ? 1 : lane_cfg.period;
                len = (lane_cfg.count == 0) ? 1 :
                      (lane_cfg.count > MAX_STEPS) ? MAX_STEPS : lane_cfg.count;
                phase_cnt++;
                if (phase_cnt >= per) begin
                    phase_cnt -= per;
                    step_pos = (step_pos + 1) % len;
                    muted = 1'b0;
                    if (hold_cnt == 0 && env_ph == EG_IDLE) begin
                        d = $signed(lane_cfg.dyn);
                        if (d < -32767)
                            d = -32767;
                        m = (d < 0) ? -d : d;
                        cube = (((m * m) >> 15) * m) >> 15;
                        if (d > 0 && r.chance < 2 * cube) begin
                            jq = 58982 + ((longint'(r.jitter) * 13107) >> 16);
                            h = lane_cfg.rise_t + ((longint'(len) * per * jq) >> 16);
                            hold_cnt = 32'((h > HOLD_MAX) ? HOLD_MAX : h);
                            note_pitch = pitch_mem[step_pos];
                            env_ph = EG_RISE;
                            holds_chosen++;
                        end
                        else if (d < 0 && r.chance < 2 * cube) begin
                            muted = 1'b1;
                            env_lvl = 0;
                            env_ph = EG_IDLE;
                            drops_chosen++;
                        end
                        else begin
                            note_pitch = pitch_mem[step_pos];
                            env_ph = EG_RISE;
                        end
                    end
                end
            end
            else begin
                phase_cnt = 0;
                step_pos = 0;
                hold_cnt = 0;
                muted = 1'b0;
                env_lvl = 0;
                env_ph = EG_IDLE;
            end
            case (env_ph)
                EG_RISE:
                begin
                    s = (lane_cfg.rise_s == 0) ? ENV_FULL : lane_cfg.rise_s;
                    env_lvl = (env_lvl + s >= ENV_FULL) ? ENV_FULL : env_lvl + s;
                    if (env_lvl == ENV_FULL)
                        env_ph = (hold_cnt > 0) ? EG_PEAK : EG_FALL;
                end
                EG_PEAK:
                begin
                    env_lvl = ENV_FULL;
                    if (hold_cnt == 0)
                        env_ph = EG_FALL;
                end
                EG_FALL:
                begin
                    s = (lane_cfg.fall_s == 0) ? ENV_FULL : lane_cfg.fall_s;
                    if (env_lvl <= s) begin
                        env_lvl = 0;
                        env_ph = EG_IDLE;
                    end
                    else begin
                        env_lvl -= s;
                    end
                end
                default:
                begin
                end
            endcase
        end
        o.pitch = (lane_running && !muted) ? note_pitch : '0;
        o.env   = env_lvl[ENV_W-1:0];
        o.run   = lane_running;
        return o;
    endfunction

    task automatic send_req(input lane_req_t r, input logic typed, input lane_out_t want);
        lane_out_t model;
        int        gap;
        if (!quiet && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 12);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= r.cmd;
        s_tdata  <= {3'b000, r.jitter, r.chance, r.pitch, r.idx, r.btn};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        model = lane_predict(r);
        due_outs.push_back(typed ? want : model);
        items_sent++;
    endtask

    task automatic settle(input int tail);
        s_tvalid <= 1'b0;
        while (due_outs.size() != 0) @(posedge clk);
        repeat (tail) @(posedge clk);
    endtask

    task automatic put_reg(input cfg_index_t i, input logic [CFG_W-1:0] v);
        wr_en    <= 1'b1;
        wr_index <= i;
        wr_data  <= v;
        @(posedge clk);
    endtask

    task automatic apply_cfg(input lane_cfg_t c);
        settle(4);
        put_reg(CFG_STEP_COUNT, CFG_W'(c.count));
        put_reg(CFG_PERIOD,     CFG_W'(c.period));
        put_reg(CFG_DYNAMICS,   CFG_W'(c.dyn));
        put_reg(CFG_RISE_TICKS, CFG_W'(c.rise_t));
        put_reg(CFG_RISE_STEP,  CFG_W'(c.rise_s));
        put_reg(CFG_FALL_STEP,  CFG_W'(c.fall_s));
        wr_en <= 1'b0;
        lane_cfg = c;
        settings_used++;
    endtask

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial begin : watchdog
        #600000;
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin : rx_side
        int        idle_left;
        int        stall_left;
        bit        held_off;
        lane_out_t got;
        lane_out_t want;
        idle_left = 0;
        stall_left = 0;
        held_off = 1'b0;
        @(posedge rst_n);
        forever begin
            @(posedge clk);
            if (m_tvalid && m_tready) begin
                got.pitch = m_tdata[OUT_PITCH_LSB +: PITCH_W];
                got.env   = m_tdata[OUT_ENV_LSB +: ENV_W];
                got.run   = m_tdata[OUT_RUN_BIT];
                outs_seen++;
                if (due_outs.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result pitch=%h env=%h run=%b",
                                 got.pitch, got.env, got.run);
                end
                else begin
                    want = due_outs.pop_front();
                    if (got.pitch !== want.pitch || got.env !== want.env ||
                        got.run !== want.run) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("result %0d: pitch %h/%h env %h/%h run %b/%b (exp/got)",
                                     outs_seen, want.pitch, got.pitch, want.env, got.env,
                                     want.run, got.run);
                    end
                end
            end
            // one long back-pressure stretch so the lane fills and stalls requests
            if (!held_off && outs_seen >= 150) begin
                held_off = 1'b1;
                stall_left = 300;
            end
            if (stall_left > 0)
                stall_left--;
            else if (idle_left > 0)
                idle_left--;
            else if (!quiet && $urandom_range(0, 7) == 0)
                idle_left = $urandom_range(1, 12);
            m_tready <= (stall_left == 0 && idle_left == 0);
        end
    end

    initial begin : stim
        lane_req_t r;
        lane_out_t none;
        lane_cfg_t dir_cfg;
        logic      btn_lvl;
        int        p;
        int        k;
        none = '0;
        btn_lvl = 1'b0;
        lane_running = 1'b0;
        btn_was = 1'b0;
        step_pos = 0;
        phase_cnt = 0;
        hold_cnt = 0;
        note_pitch = '0;
        muted = 1'b0;
        env_lvl = 0;
        env_ph = EG_IDLE;
        foreach (pitch_mem[i])
            pitch_mem[i] = '0;
        lane_cfg = '{5'd3, 22'd24000, 16'h0000, 17'd0, 24'hFFFFFF, 24'd699};
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // one step per tick, zero fall step acts as instant decay
        dir_cfg = '{5'd3, 22'd1, 16'h0000, 17'd0, 24'hFFFFFF, 24'h000000};
        apply_cfg(dir_cfg);
        for (k = 0; k < DIR_N; k++)
            send_req(dir_tab[k].req, dir_tab[k].typed, dir_tab[k].want);

        for (p = 0; p < N_PHASES; p++) begin
            apply_cfg(phase_cfg[p]);
            quiet = (p == N_PHASES - 1);
            for (k = 0; k < PHASE_ITEMS; k++) begin
                if ($urandom_range(0, btn_odds[p] - 1) == 0)
                    btn_lvl = !btn_lvl;
                r.cmd    = ($urandom_range(0, 7) == 0) ? CMD_WRITE : CMD_TICK;
                r.btn    = ($urandom_range(0, 19) == 0) ? 1'($urandom_range(0, 1)) : btn_lvl;
                r.idx    = IDX_W'($urandom_range(0, 15));
                r.pitch  = PITCH_W'($urandom_range(0, 65535));
                r.chance = ($urandom_range(0, 2) == 0) ? DRAW_W'($urandom_range(0, 1023))
                                                       : DRAW_W'($urandom_range(0, 65535));
                case ($urandom_range(0, 5))
                    0:       r.jitter = '0;
                    1:       r.jitter = '1;
                    default: r.jitter = DRAW_W'($urandom_range(0, 65535));
                endcase
                send_req(r, 1'b0, none);
            end
        end

        settle(20);
        $display("%0d requests sent, %0d results checked, %0d register settings",
                 items_sent, outs_seen, settings_used);
        $display("lane chose %0d held notes and %0d dropped notes", holds_chosen, drops_chosen);
        if (mismatches == 0 && due_outs.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
